[rtl/jst_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and byte classes for the JSON structure tokenizer.
// No dependencies; every other file of the block imports this package.

package jst_pkg;

    typedef enum logic [2:0] {
        MODE_SCAN = 3'd0,
        MODE_STR  = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_BOOL = 3'd3,
        MODE_ERR  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_OBJ  = 2'd1,
        MARK_ARR  = 2'd2,
        MARK_KEY  = 2'd3
    } t_mark;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_OBJ_START = 4'd1,
        EV_OBJ_END   = 4'd2,
        EV_ARR_START = 4'd3,
        EV_ARR_END   = 4'd4,
        EV_KEY_CHAR  = 4'd5,
        EV_KEY_END   = 4'd6,
        EV_STR_CHAR  = 4'd7,
        EV_STR_END   = 4'd8,
        EV_NUM_CHAR  = 4'd9,
        EV_NUM_END   = 4'd10,
        EV_BOOL_CHAR = 4'd11,
        EV_BOOL_END  = 4'd12,
        EV_ERROR     = 4'd13
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OBJ_START = 3'd1,
        ERR_OBJ_END   = 3'd2,
        ERR_ARR_START = 3'd3,
        ERR_ARR_END   = 3'd4,
        ERR_VALUE     = 3'd5,
        ERR_OVERFLOW  = 3'd6
    } t_err;

    // Control for one cycle of the stack cell chain.
    typedef struct packed {
        logic       push;
        logic [1:0] pop_cnt;
        t_mark      push_mark;
    } t_stack_ctl;

    typedef struct packed {
        t_event     ev;
        logic [7:0] ch;
        logic [5:0] depth;
        t_err       err;
        logic       last;
    } t_result;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic f_is_num_start(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_N || b == CH_DOT;
    endfunction

    function automatic logic f_is_num_body(input logic [7:0] b);
        return f_is_num_start(b) || b == CH_U || b == CH_L;
    endfunction

    function automatic logic f_is_bool_body(input logic [7:0] b);
        return b == CH_T || b == CH_R || b == CH_U || b == CH_E || b == CH_F ||
               b == CH_A || b == CH_L || b == CH_S;
    endfunction

    function automatic logic f_is_delim(input logic [7:0] b);
        return b == CH_COMMA || b == CH_SPACE || b == CH_RBRACK || b == CH_RBRACE ||
               b == CH_LF;
    endfunction

endpackage

[rtl/json_structure_tokenizer_unit.sv]
`timescale 1ns / 1ps
// JSON structure tokenizer: one text byte in per transfer, one or two
// structural or character events out per byte.
// Depends on jst_pkg and jst_stack.
//
// Input channel: i_valid / o_stall with i_data_byte. Output channel:
// o_valid / i_stall with the event fields; o_last_of_item marks the final
// event of a byte. A byte is decoded in the cycle of its transfer, the stack
// chain and the mode register update at that edge, and its events enter the
// result queue at that edge. Bytes are taken one per cycle while o_stall is
// low; a byte that ends a number or bool with a closing bracket yields two
// events, in two queue entries. Events wait in a four-entry queue; o_stall
// goes high while more than two entries are held, so a stalled receiver
// stops the input within the queue's slack and nothing is lost. The rate is
// set by the output side: one event per cycle while i_stall is low.
// Reset (synchronous, i_rst_n low) empties the queue and the stack, clears
// the sticky error and returns to scanning. After an error every byte yields
// a single error event until the next reset.

module json_structure_tokenizer_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_res,
    output logic [7:0]  o_char_out,
    output logic [5:0]  o_nest_depth,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_item
);
    import jst_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    function automatic logic [5:0] f_depth6(input logic [CW-1:0] c);
        logic [CW+5:0] e;
        e = {6'd0, c};
        return e[5:0];
    endfunction

    // Control state.
    t_mode          r_mode,  n_mode;
    logic [7:0]     r_quote, n_quote;
    logic           r_key,   n_key;
    logic [7:0]     r_prev;
    logic [CW-1:0]  r_count, n_count;
    t_err           r_err,   n_err;

    // Result queue.
    t_result        r_q [0:3];
    logic [1:0]     r_wr;
    logic [1:0]     r_rd;
    logic [2:0]     r_qcnt;

    logic           w_in_acc;
    logic           w_out_acc;
    logic [7:0]     w_b;

    t_mark          w_top0, w_top1, w_top2;
    t_mark          w_kd0, w_kd1, w_kd2;
    t_mark          w_kb, w_kb_next;
    logic           w_full;
    logic           w_delim;
    logic           w_close;
    logic           w_d1;
    logic           w_quote_end;
    logic           w_opener;

    t_event         w_br_ev;
    t_err           w_br_err;
    logic           w_br_push;
    t_mark          w_br_mark;
    logic [1:0]     w_br_pops;
    logic [CW-1:0]  w_cnt_base;
    logic [CW-1:0]  w_cnt_br;

    t_result        w_res0, w_res1;
    logic           w_two;
    t_stack_ctl     w_ctl, w_ctl_gated;

    assign w_b       = i_data_byte;
    assign o_stall   = r_qcnt > 3'd2;
    assign o_valid   = r_qcnt != 3'd0;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    jst_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl_gated),
        .o_top0 (w_top0),
        .o_top1 (w_top1),
        .o_top2 (w_top2)
    );

    // Marks at the top three places, empty where the stack is shallower.
    assign w_kd0 = (r_count > CW'(0)) ? w_top0 : MARK_NONE;
    assign w_kd1 = (r_count > CW'(1)) ? w_top1 : MARK_NONE;
    assign w_kd2 = (r_count > CW'(2)) ? w_top2 : MARK_NONE;
    assign w_full = r_count == CW'(STACK_DEPTH);

    assign w_delim = f_is_delim(w_b);
    assign w_close = w_b == CH_RBRACK || w_b == CH_RBRACE;
    assign w_quote_end = w_b == r_quote && r_prev != CH_BSLASH;
    assign w_opener = (w_b == CH_DQUOTE || w_b == CH_SQUOTE || w_b == CH_LBRACE ||
                       w_b == CH_RBRACE || w_b == CH_LBRACK || w_b == CH_RBRACK ||
                       w_b == CH_T || w_b == CH_F || f_is_num_start(w_b)) &&
                      r_prev != CH_BSLASH;

    // A delimiter that ends a value first drops a key from the top, and a
    // closing bracket then looks at the mark under it.
    assign w_d1 = (r_mode == MODE_NUM || r_mode == MODE_BOOL) && w_delim &&
                  w_kd0 == MARK_KEY;
    assign w_kb      = w_d1 ? w_kd1 : w_kd0;
    assign w_kb_next = w_d1 ? w_kd2 : w_kd1;

    always_comb begin
        logic obj;
        obj       = w_b == CH_LBRACE;
        w_br_ev   = EV_NONE;
        w_br_err  = ERR_NONE;
        w_br_push = 1'b0;
        w_br_mark = MARK_NONE;
        w_br_pops = 2'd0;
        case (w_b)
            CH_LBRACE, CH_LBRACK: begin
                if (w_kb == MARK_OBJ) begin
                    w_br_err = obj ? ERR_OBJ_START : ERR_ARR_START;
                end else if (w_full) begin
                    w_br_err = ERR_OVERFLOW;
                end else begin
                    w_br_push = 1'b1;
                    w_br_mark = obj ? MARK_OBJ : MARK_ARR;
                    w_br_ev   = obj ? EV_OBJ_START : EV_ARR_START;
                end
            end
            CH_RBRACE: begin
                if (w_kb != MARK_OBJ) begin
                    w_br_err = ERR_OBJ_END;
                end else begin
                    w_br_ev   = EV_OBJ_END;
                    w_br_pops = 2'd1 + {1'b0, w_kb_next == MARK_KEY};
                end
            end
            default: begin
                if (w_kb != MARK_ARR) begin
                    w_br_err = ERR_ARR_END;
                end else begin
                    w_br_ev   = EV_ARR_END;
                    w_br_pops = 2'd1 + {1'b0, w_kb_next == MARK_KEY};
                end
            end
        endcase
    end

    assign w_cnt_base = r_count - CW'(w_d1);
    assign w_cnt_br   = w_cnt_base - CW'(w_br_pops) + CW'(w_br_push);

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_ERR: n_mode = MODE_ERR;
            MODE_STR: begin
                if (w_quote_end) begin
                    n_mode = (r_key && w_full) ? MODE_ERR : MODE_SCAN;
                end
            end
            MODE_NUM, MODE_BOOL: begin
                if (w_delim) begin
                    n_mode = (w_close && w_br_err != ERR_NONE) ? MODE_ERR : MODE_SCAN;
                end else if ((r_mode == MODE_NUM) ? f_is_num_body(w_b)
                                                  : f_is_bool_body(w_b)) begin
                    n_mode = r_mode;
                end else begin
                    n_mode = MODE_ERR;
                end
            end
            default: begin
                // Scanning between values.
                n_mode = MODE_SCAN;
                if (w_opener) begin
                    if (w_b == CH_DQUOTE || w_b == CH_SQUOTE) begin
                        n_mode = MODE_STR;
                    end else if (f_is_num_start(w_b)) begin
                        n_mode = MODE_NUM;
                    end else if (w_b == CH_T || w_b == CH_F) begin
                        n_mode = MODE_BOOL;
                    end else if (w_br_err != ERR_NONE) begin
                        n_mode = MODE_ERR;
                    end
                end
            end
        endcase
    end

    // Results, stack control and the remaining state.
    always_comb begin
        w_res0    = '{ev: EV_NONE, ch: 8'd0, depth: f_depth6(r_count), err: r_err,
                      last: 1'b1};
        w_res1    = w_res0;
        w_two     = 1'b0;
        w_ctl     = '{push: 1'b0, pop_cnt: 2'd0, push_mark: MARK_NONE};
        n_count   = r_count;
        n_err     = r_err;
        n_quote   = r_quote;
        n_key     = r_key;
        case (r_mode)
            MODE_ERR: begin
                w_res0.ev = EV_ERROR;
            end
            MODE_STR: begin
                if (w_quote_end) begin
                    if (r_key) begin
                        if (w_full) begin
                            n_err      = ERR_OVERFLOW;
                            w_res0.ev  = EV_ERROR;
                            w_res0.err = ERR_OVERFLOW;
                        end else begin
                            w_ctl.push      = 1'b1;
                            w_ctl.push_mark = MARK_KEY;
                            n_count         = r_count + CW'(1);
                            w_res0.ev       = EV_KEY_END;
                            w_res0.depth    = f_depth6(n_count);
                        end
                    end else begin
                        if (w_kd0 == MARK_KEY) begin
                            w_ctl.pop_cnt = 2'd1;
                            n_count       = r_count - CW'(1);
                        end
                        w_res0.ev    = EV_STR_END;
                        w_res0.depth = f_depth6(n_count);
                    end
                end else if (w_b != CH_LF) begin
                    w_res0.ev = r_key ? EV_KEY_CHAR : EV_STR_CHAR;
                    w_res0.ch = w_b;
                end
            end
            MODE_NUM, MODE_BOOL: begin
                if (w_delim) begin
                    w_res0.ev    = (r_mode == MODE_NUM) ? EV_NUM_END : EV_BOOL_END;
                    w_res0.depth = f_depth6(w_cnt_base);
                    n_count      = w_cnt_base;
                    w_ctl.pop_cnt = {1'b0, w_d1};
                    if (w_close) begin
                        w_two         = 1'b1;
                        w_res0.last   = 1'b0;
                        n_count       = w_cnt_br;
                        w_ctl.pop_cnt = {1'b0, w_d1} + w_br_pops;
                        w_res1.depth  = f_depth6(w_cnt_br);
                        if (w_br_err != ERR_NONE) begin
                            n_err      = w_br_err;
                            w_res1.ev  = EV_ERROR;
                            w_res1.err = w_br_err;
                        end else begin
                            w_res1.ev  = w_br_ev;
                        end
                    end
                end else if ((r_mode == MODE_NUM) ? f_is_num_body(w_b)
                                                  : f_is_bool_body(w_b)) begin
                    w_res0.ev = (r_mode == MODE_NUM) ? EV_NUM_CHAR : EV_BOOL_CHAR;
                    w_res0.ch = w_b;
                end else begin
                    n_err      = ERR_VALUE;
                    w_res0.ev  = EV_ERROR;
                    w_res0.err = ERR_VALUE;
                end
            end
            default: begin
                // Scanning between values.
                if (w_opener) begin
                    if (w_b == CH_DQUOTE || w_b == CH_SQUOTE) begin
                        n_quote = w_b;
                        n_key   = w_kd0 == MARK_OBJ;
                    end else if (f_is_num_start(w_b)) begin
                        w_res0.ev = EV_NUM_CHAR;
                        w_res0.ch = w_b;
                    end else if (w_b == CH_T || w_b == CH_F) begin
                        w_res0.ev = EV_BOOL_CHAR;
                        w_res0.ch = w_b;
                    end else begin
                        n_count         = w_cnt_br;
                        w_ctl.push      = w_br_push;
                        w_ctl.push_mark = w_br_mark;
                        w_ctl.pop_cnt   = w_br_pops;
                        w_res0.depth    = f_depth6(w_cnt_br);
                        if (w_br_err != ERR_NONE) begin
                            n_err      = w_br_err;
                            w_res0.ev  = EV_ERROR;
                            w_res0.err = w_br_err;
                        end else begin
                            w_res0.ev  = w_br_ev;
                        end
                    end
                end
            end
        endcase
    end

    assign w_ctl_gated = w_in_acc ? w_ctl
                                  : '{push: 1'b0, pop_cnt: 2'd0, push_mark: MARK_NONE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SCAN;
            r_quote <= 8'd0;
            r_key   <= 1'b0;
            r_prev  <= 8'd0;
            r_count <= '0;
            r_err   <= ERR_NONE;
        end else if (w_in_acc) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_key   <= n_key;
            r_prev  <= w_b;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // Result queue: one or two writes per input transfer, one read per
    // output transfer.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_q[r_wr] <= w_res0;
            if (w_two) begin
                r_q[r_wr + 2'd1] <= w_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 2'd0;
            r_rd   <= 2'd0;
            r_qcnt <= 3'd0;
        end else begin
            if (w_in_acc) begin
                r_wr <= r_wr + {w_two, !w_two};
            end
            if (w_out_acc) begin
                r_rd <= r_rd + 2'd1;
            end
            r_qcnt <= r_qcnt + (w_in_acc ? {1'b0, w_two, !w_two} : 3'd0)
                             - {2'b00, w_out_acc};
        end
    end

    assign o_event_res    = r_q[r_rd].ev;
    assign o_char_out     = r_q[r_rd].ch;
    assign o_nest_depth   = r_q[r_rd].depth;
    assign o_error_code   = r_q[r_rd].err;
    assign o_last_of_item = r_q[r_rd].last;

endmodule

[rtl/jst_cell.sv]
`timescale 1ns / 1ps
// One entry of the nesting stack: holds a two-bit mark and moves it toward
// the top or the bottom with its neighbors. Depends on jst_pkg.

module jst_cell (
    input  logic                   i_clk,
    input  jst_pkg::t_stack_ctl    i_ctl,
    input  jst_pkg::t_mark         i_up,
    input  jst_pkg::t_mark         i_dn1,
    input  jst_pkg::t_mark         i_dn2,
    input  jst_pkg::t_mark         i_dn3,
    output jst_pkg::t_mark         o_mark
);
    import jst_pkg::*;

    t_mark r_mark;
    t_mark n_mark;

    always_comb begin
        if (i_ctl.push) begin
            n_mark = i_up;
        end else begin
            case (i_ctl.pop_cnt)
                2'd0:    n_mark = r_mark;
                2'd1:    n_mark = i_dn1;
                2'd2:    n_mark = i_dn2;
                2'd3:    n_mark = i_dn3;
                default: n_mark = r_mark;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mark <= n_mark;
    end

    assign o_mark = r_mark;

endmodule

[rtl/jst_stack.sv]
`timescale 1ns / 1ps
// Nesting stack built as a chain of jst_cell entries with the top at cell 0.
// Depends on jst_pkg and jst_cell.

module jst_stack #(
    parameter int DEPTH = 32
) (
    input  logic                   i_clk,
    input  jst_pkg::t_stack_ctl    i_ctl,
    output jst_pkg::t_mark         o_top0,
    output jst_pkg::t_mark         o_top1,
    output jst_pkg::t_mark         o_top2
);
    import jst_pkg::*;

    // Three extra slots past the bottom read as empty during pops.
    t_mark w_mark [0:DEPTH+2];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_mark w_up;
            if (gi == 0) begin : g_head
                assign w_up = i_ctl.push_mark;
            end else begin : g_body
                assign w_up = w_mark[gi-1];
            end
            jst_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (i_ctl),
                .i_up   (w_up),
                .i_dn1  (w_mark[gi+1]),
                .i_dn2  (w_mark[gi+2]),
                .i_dn3  (w_mark[gi+3]),
                .o_mark (w_mark[gi])
            );
        end
        for (gi = DEPTH; gi < DEPTH + 3; gi++) begin : g_tail
            assign w_mark[gi] = MARK_NONE;
        end
    endgenerate

    assign o_top0 = w_mark[0];
    assign o_top1 = w_mark[1];
    assign o_top2 = w_mark[2];

endmodule

[tb/sv/jst_event_checker.sv]
`timescale 1ns / 1ps
// Event checker for the JSON structure tokenizer: watches both channels,
// predicts the events of every accepted byte and compares them in order.
// Depends on jst_pkg for the event, mark, mode and error types.

module jst_event_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [3:0] i_event,
    input  logic [7:0] i_char,
    input  logic [5:0] i_depth,
    input  logic [2:0] i_err,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);
    import jst_pkg::*;

    t_mode      tk_mode;
    logic [7:0] tk_quote;
    logic       tk_key;
    logic [7:0] tk_prev;
    t_mark      tk_stack [STACK_DEPTH];
    int         tk_count;
    t_err       tk_err;

    t_result    byte_events[$];
    t_result    expected_events[$];
    int         mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic logic num_lead(input logic [7:0] b);
        return (b >= "0" && b <= "9") || b == "-" || b == "n" || b == ".";
    endfunction

    function automatic logic num_tail(input logic [7:0] b);
        return num_lead(b) || b == "u" || b == "l";
    endfunction

    function automatic logic bool_tail(input logic [7:0] b);
        return b == "t" || b == "r" || b == "u" || b == "e" || b == "f" ||
               b == "a" || b == "l" || b == "s";
    endfunction

    function automatic logic value_delim(input logic [7:0] b);
        return b == "," || b == " " || b == "]" || b == "}" || b == "\n";
    endfunction

    function automatic t_mark top_mark();
        if (tk_count == 0) return MARK_NONE;
        return tk_stack[tk_count - 1];
    endfunction

    function automatic logic push_mark(input t_mark m);
        if (tk_count >= STACK_DEPTH) return 1'b0;
        tk_stack[tk_count] = m;
        tk_count++;
        return 1'b1;
    endfunction

    function automatic void drop_key();
        if (top_mark() == MARK_KEY) tk_count--;
    endfunction

    function automatic void add_event(input t_event ev, input logic [7:0] ch);
        t_result r;
        r.ev    = ev;
        r.ch    = ch;
        r.depth = 6'(tk_count);
        r.err   = tk_err;
        r.last  = 1'b0;
        byte_events.push_back(r);
    endfunction

    function automatic void raise_error(input t_err code);
        tk_err  = code;
        tk_mode = MODE_ERR;
        add_event(EV_ERROR, 8'h00);
    endfunction

    function automatic void bracket_byte(input logic [7:0] b);
        logic is_obj;
        if (b == "{" || b == "[") begin
            is_obj = (b == "{");
            if (top_mark() == MARK_OBJ) begin
                raise_error(is_obj ? ERR_OBJ_START : ERR_ARR_START);
            end else if (!push_mark(is_obj ? MARK_OBJ : MARK_ARR)) begin
                raise_error(ERR_OVERFLOW);
            end else begin
                add_event(is_obj ? EV_OBJ_START : EV_ARR_START, 8'h00);
            end
        end else if (b == "}") begin
            if (top_mark() != MARK_OBJ) begin
                raise_error(ERR_OBJ_END);
            end else begin
                // Closing a container also removes the key that named it.
                tk_count--;
                drop_key();
                add_event(EV_OBJ_END, 8'h00);
            end
        end else begin
            if (top_mark() != MARK_ARR) begin
                raise_error(ERR_ARR_END);
            end else begin
                tk_count--;
                drop_key();
                add_event(EV_ARR_END, 8'h00);
            end
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic opener;
        opener = b == "\"" || b == "'" || b == "{" || b == "}" || b == "[" ||
                 b == "]" || b == "t" || b == "f" || num_lead(b);
        if (!opener || tk_prev == "\\") begin
            add_event(EV_NONE, 8'h00);
        end else if (b == "\"" || b == "'") begin
            tk_mode  = MODE_STR;
            tk_quote = b;
            tk_key   = (top_mark() == MARK_OBJ);
            add_event(EV_NONE, 8'h00);
        end else if (num_lead(b)) begin
            tk_mode = MODE_NUM;
            add_event(EV_NUM_CHAR, b);
        end else if (b == "t" || b == "f") begin
            tk_mode = MODE_BOOL;
            add_event(EV_BOOL_CHAR, b);
        end else begin
            bracket_byte(b);
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b);
        logic    is_num;
        t_result r;
        byte_events.delete();
        case (tk_mode)
            MODE_ERR: add_event(EV_ERROR, 8'h00);
            MODE_STR: begin
                if (b == tk_quote && tk_prev != "\\") begin
                    tk_mode = MODE_SCAN;
                    if (tk_key) begin
                        if (!push_mark(MARK_KEY)) raise_error(ERR_OVERFLOW);
                        else add_event(EV_KEY_END, 8'h00);
                    end else begin
                        drop_key();
                        add_event(EV_STR_END, 8'h00);
                    end
                end else if (b == "\n") begin
                    add_event(EV_NONE, 8'h00);
                end else begin
                    add_event(tk_key ? EV_KEY_CHAR : EV_STR_CHAR, b);
                end
            end
            MODE_NUM, MODE_BOOL: begin
                is_num = (tk_mode == MODE_NUM);
                if (value_delim(b)) begin
                    // The delimiter ends the value; a closing bracket is then taken as structure.
                    tk_mode = MODE_SCAN;
                    drop_key();
                    add_event(is_num ? EV_NUM_END : EV_BOOL_END, 8'h00);
                    if (b == "]" || b == "}") bracket_byte(b);
                end else if (is_num ? num_tail(b) : bool_tail(b)) begin
                    add_event(is_num ? EV_NUM_CHAR : EV_BOOL_CHAR, b);
                end else begin
                    raise_error(ERR_VALUE);
                end
            end
            default: begin
                tk_mode = MODE_SCAN;
                scan_byte(b);
            end
        endcase
        r = byte_events[byte_events.size() - 1];
        r.last = 1'b1;
        byte_events[byte_events.size() - 1] = r;
        foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
        tk_prev = b;
    endfunction

    function automatic void clear_tokenizer();
        tk_mode  = MODE_SCAN;
        tk_quote = 8'h00;
        tk_key   = 1'b0;
        tk_prev  = 8'h00;
        tk_count = 0;
        tk_err   = ERR_NONE;
        foreach (tk_stack[i]) tk_stack[i] = MARK_NONE;
        expected_events.delete();
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: event mismatch on %s: got %h, expected %h",
                 $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_event();
        t_result want;
        if (expected_events.size() == 0) begin
            report_mismatch("unexpected transfer", {4'h0, i_event}, 8'h00);
            return;
        end
        want = expected_events.pop_front();
        if (i_event !== want.ev)
            report_mismatch("event", {4'h0, i_event}, {4'h0, want.ev});
        if (i_char !== want.ch)
            report_mismatch("char", i_char, want.ch);
        if (i_depth !== want.depth)
            report_mismatch("depth", {2'b00, i_depth}, {2'b00, want.depth});
        if (i_err !== want.err)
            report_mismatch("error code", {5'h0, i_err}, {5'h0, want.err});
        if (i_last !== want.last)
            report_mismatch("last", {7'h0, i_last}, {7'h0, want.last});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tokenizer();
        end else begin
            if (i_in_valid && !i_in_stall) tokenize_byte(i_in_byte);
            if (i_out_valid && !i_out_stall) check_event();
        end
        o_pending <= expected_events.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the JSON structure tokenizer bench: clock, reset, byte stimulus and
// receiver stalls around the block, with the verdict taken from the checker.
// Depends on jst_pkg, json_structure_tokenizer_unit and jst_event_checker.

module tb;
    import jst_pkg::*;

    localparam int NEST_LIMIT = 32;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] ev_res;
    logic [7:0] ev_char;
    logic [5:0] ev_depth;
    logic [2:0] ev_err;
    logic       ev_last;
    int         mismatches;
    int         pending;

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_trigger = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         bytes_sent = 0;
    logic [7:0] text_q[$];

    always #5 clk = ~clk;

    json_structure_tokenizer_unit #(.STACK_DEPTH(NEST_LIMIT)) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_data_byte   (in_byte),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_event_res   (ev_res),
        .o_char_out    (ev_char),
        .o_nest_depth  (ev_depth),
        .o_error_code  (ev_err),
        .o_last_of_item(ev_last)
    );

    jst_event_checker #(.STACK_DEPTH(NEST_LIMIT)) u_event_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_byte   (in_byte),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_event     (ev_res),
        .i_char      (ev_char),
        .i_depth     (ev_depth),
        .i_err       (ev_err),
        .i_last      (ev_last),
        .o_fail_count(mismatches),
        .o_pending   (pending)
    );

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks.
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic logic noise_unsafe(input logic [7:0] c);
        return (c >= "0" && c <= "9") ||
               c inside {"-", "n", ".", "t", "f", "\"", "'", "{", "}", "[", "]", "\\"};
    endfunction

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic add_literal(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Bytes that start nothing while scanning; never a backslash, which
    // would hide the token after it.
    task automatic add_noise();
        logic [7:0] c;
        repeat ($urandom_range(0, 1) * $urandom_range(1, 2)) begin
            do c = 8'($urandom_range(0, 255)); while (noise_unsafe(c));
            text_q.push_back(c);
        end
    endtask

    task automatic add_string();
        logic [7:0] q;
        logic [7:0] c;
        q = ($urandom_range(0, 3) == 0) ? "'" : "\"";
        text_q.push_back(q);
        repeat ($urandom_range(0, 6)) begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
            if (c == q) text_q.push_back("\\");
            text_q.push_back(c);
        end
        // A trailing backslash would swallow the closing quote.
        if (text_q[text_q.size() - 1] == "\\") text_q.push_back("x");
        text_q.push_back(q);
    endtask

    task automatic add_scalar();
        case ($urandom_range(0, 5))
            0, 1: add_string();
            2: add_literal("null");
            3: begin
                if ($urandom_range(0, 1)) add_literal("true");
                else add_literal("false");
            end
            4: begin
                text_q.push_back($urandom_range(0, 1) ? "t" : "f");
                repeat ($urandom_range(0, 5)) text_q.push_back(pick_char("truefals"));
            end
            default: begin
                text_q.push_back(pick_char("0123456789-n."));
                repeat ($urandom_range(0, 5)) text_q.push_back(pick_char("0123456789-n.ul"));
            end
        endcase
    endtask

    // Well-formed document with random content. Stack use (containers plus
    // pending keys) is tracked so that it never passes the block's depth.
    task automatic build_document(input int nest_cap, input int budget, input int open_pct);
        bit is_obj[$];
        int elem_count[$];
        int entries;
        bit obj_now;
        obj_now = 1'($urandom_range(0, 1));
        text_q.push_back(obj_now ? "{" : "[");
        is_obj.push_back(obj_now);
        elem_count.push_back(0);
        entries = 1;
        add_noise();
        while (is_obj.size() > 0) begin
            obj_now = is_obj[is_obj.size() - 1];
            if (budget <= 0 || (obj_now && entries >= NEST_LIMIT) ||
                (elem_count[elem_count.size() - 1] > 0 && $urandom_range(0, 3) == 0)) begin
                text_q.push_back(obj_now ? "}" : "]");
                void'(is_obj.pop_back());
                void'(elem_count.pop_back());
                entries--;
                if (is_obj.size() > 0 && is_obj[is_obj.size() - 1]) entries--;
                if ($urandom_range(0, 3) == 0) text_q.push_back($urandom_range(0, 1) ? " " : "\n");
            end else begin
                if (elem_count[elem_count.size() - 1] > 0) begin
                    text_q.push_back(",");
                    add_noise();
                end
                elem_count[elem_count.size() - 1] = elem_count[elem_count.size() - 1] + 1;
                if (obj_now) begin
                    add_string();
                    text_q.push_back(":");
                    entries++;
                    add_noise();
                end
                if (is_obj.size() < nest_cap && entries < NEST_LIMIT &&
                    $urandom_range(0, 99) < open_pct) begin
                    obj_now = 1'($urandom_range(0, 1));
                    text_q.push_back(obj_now ? "{" : "[");
                    is_obj.push_back(obj_now);
                    elem_count.push_back(0);
                    entries++;
                    add_noise();
                end else begin
                    add_scalar();
                    budget--;
                    if (is_obj[is_obj.size() - 1]) entries--;
                    // Only a real delimiter may follow a number or bool.
                    if ($urandom_range(0, 3) == 0)
                        text_q.push_back($urandom_range(0, 1) ? " " : "\n");
                end
            end
        end
    endtask

    // One broken sequence of a random kind; the error is sticky, so this
    // closes the run, followed by arbitrary bytes.
    task automatic add_error_tail();
        t_err pick;
        bit   alt;
        pick = t_err'($urandom_range(int'(ERR_OBJ_START), int'(ERR_OVERFLOW)));
        alt  = 1'($urandom_range(0, 1));
        case (pick)
            ERR_OBJ_START: if (alt) add_literal("{{"); else add_literal("[{{");
            ERR_OBJ_END:   if (alt) add_literal("}"); else add_literal("[1}");
            ERR_ARR_START: if (alt) add_literal("{["); else add_literal("[{[");
            ERR_ARR_END:   if (alt) add_literal("]"); else add_literal("{\"a\":1]");
            ERR_VALUE:     if (alt) add_literal("[1x"); else add_literal("[tz");
            default: begin
                if (alt) begin
                    repeat (NEST_LIMIT + 1) text_q.push_back("[");
                end else begin
                    repeat (NEST_LIMIT - 1) text_q.push_back("[");
                    add_literal("{'k'");
                end
            end
        endcase
        repeat (20) text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int send_pcts [4] = '{0, 49, 0, 35};
        int recv_pcts [4] = '{0, 0, 49, 35};
        int phase;
        int target;
        bit held;
        held = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Escaped quote in a key, a bracket closing a number, extreme bytes
        // and a newline in a key, a bool closed by a brace, an escaped brace
        // while scanning, and a double quote inside a single-quoted string.
        add_literal("{'k\\'':[0],\"");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back("\n");
        add_literal("\":t}\\{[-,'\"']");
        send_text();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            target = bytes_sent + 465;
            while (bytes_sent < target) begin
                // Long receiver hold-off while bytes keep coming in.
                if (phase == 0 && !held && bytes_sent > 150) begin
                    hold_trigger++;
                    held = 1'b1;
                end
                if ($urandom_range(0, 9) == 0)
                    build_document(NEST_LIMIT, 6, 95);
                else
                    build_document($urandom_range(1, 8), $urandom_range(1, 12), 30);
                add_noise();
                send_text();
            end
            if (phase == 1) wait_drained();
        end

        add_error_tail();
        send_text();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[json_structure_tokenizer_unit] OK");
        else
            $display("[json_structure_tokenizer_unit] ERROR");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[json_structure_tokenizer_unit] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/jst_pkg.sv
rtl/jst_cell.sv
rtl/jst_stack.sv
rtl/json_structure_tokenizer_unit.sv
tb/sv/jst_event_checker.sv
tb/sv/tb.sv
